[hw/rtl/ppc_pkg.sv]
// Shared types, constants and lookup functions for the pixel priority compositor.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package ppc_pkg;

    localparam int VIEW_WIDTH  = 256;
    localparam int VIEW_HEIGHT = 240;
    localparam int STORE_COLS  = 2 * VIEW_WIDTH;
    localparam int STORE_ROWS  = 2 * VIEW_HEIGHT;
    localparam int STORE_DEPTH = STORE_COLS * STORE_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int X_W     = 9;
    localparam int Y_W     = 9;
    localparam int COLOR_W = 6;
    localparam int PRIO_W  = 6;
    localparam int CHAN_W  = 8;
    localparam int SCR_W   = 8;
    localparam int WIN_W   = 11;

    localparam int XSCR_W  = 9;
    localparam int YSCR_W  = 8;
    localparam int MASK_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_X_SCROLL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCROLL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MASK = 2'd2;

    localparam int MASK_GREY   = 0;
    localparam int MASK_RED    = 5;
    localparam int MASK_GREEN  = 6;
    localparam int MASK_BLUE   = 7;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              behind;
        logic              trans;
        logic [PRIO_W-1:0] prio;
        logic              sprite;
        logic [COLOR_W-1:0] color;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
    localparam t_entry RESET_ENTRY = '{behind: 1'b0, trans: 1'b0, prio: '0,
                                       sprite: 1'b0, color: 6'h0F};

    typedef struct packed {
        logic              func;
        logic              in_window;
        t_entry            ent;
        logic [ADDR_W-1:0] addr;
        logic [SCR_W-1:0]  scr_x;
        logic [SCR_W-1:0]  scr_y;
    } t_cmd;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [SCR_W-1:0]  scr_x;
        logic [SCR_W-1:0]  scr_y;
    } t_result;

    typedef struct packed {
        logic   empty;
        logic   full;
        t_cmd   head;
    } t_queue_stat;

    function automatic logic [3*CHAN_W-1:0] palette(input logic [COLOR_W-1:0] idx);
        logic [3*CHAN_W-1:0] rgb;
        unique case (idx)
            6'd0:  rgb = {8'd84,  8'd84,  8'd84};
            6'd1:  rgb = {8'd0,   8'd30,  8'd116};
            6'd2:  rgb = {8'd8,   8'd16,  8'd144};
            6'd3:  rgb = {8'd48,  8'd0,   8'd136};
            6'd4:  rgb = {8'd68,  8'd0,   8'd100};
            6'd5:  rgb = {8'd92,  8'd0,   8'd48};
            6'd6:  rgb = {8'd84,  8'd4,   8'd0};
            6'd7:  rgb = {8'd60,  8'd24,  8'd0};
            6'd8:  rgb = {8'd32,  8'd42,  8'd0};
            6'd9:  rgb = {8'd8,   8'd58,  8'd0};
            6'd10: rgb = {8'd0,   8'd64,  8'd0};
            6'd11: rgb = {8'd0,   8'd60,  8'd0};
            6'd12: rgb = {8'd0,   8'd50,  8'd60};
            6'd16: rgb = {8'd152, 8'd150, 8'd152};
            6'd17: rgb = {8'd8,   8'd76,  8'd196};
            6'd18: rgb = {8'd48,  8'd50,  8'd236};
            6'd19: rgb = {8'd92,  8'd30,  8'd228};
            6'd20: rgb = {8'd136, 8'd20,  8'd176};
            6'd21: rgb = {8'd160, 8'd20,  8'd100};
            6'd22: rgb = {8'd152, 8'd34,  8'd32};
            6'd23: rgb = {8'd120, 8'd60,  8'd0};
            6'd24: rgb = {8'd84,  8'd90,  8'd0};
            6'd25: rgb = {8'd40,  8'd114, 8'd0};
            6'd26: rgb = {8'd8,   8'd124, 8'd0};
            6'd27: rgb = {8'd0,   8'd118, 8'd40};
            6'd28: rgb = {8'd0,   8'd102, 8'd120};
            6'd32: rgb = {8'd236, 8'd238, 8'd236};
            6'd33: rgb = {8'd76,  8'd154, 8'd236};
            6'd34: rgb = {8'd120, 8'd124, 8'd236};
            6'd35: rgb = {8'd176, 8'd98,  8'd236};
            6'd36: rgb = {8'd228, 8'd84,  8'd236};
            6'd37: rgb = {8'd236, 8'd88,  8'd180};
            6'd38: rgb = {8'd236, 8'd106, 8'd100};
            6'd39: rgb = {8'd212, 8'd136, 8'd32};
            6'd40: rgb = {8'd160, 8'd170, 8'd0};
            6'd41: rgb = {8'd116, 8'd196, 8'd0};
            6'd42: rgb = {8'd76,  8'd208, 8'd32};
            6'd43: rgb = {8'd56,  8'd204, 8'd108};
            6'd44: rgb = {8'd56,  8'd180, 8'd204};
            6'd45: rgb = {8'd60,  8'd60,  8'd60};
            6'd48: rgb = {8'd236, 8'd238, 8'd236};
            6'd49: rgb = {8'd168, 8'd204, 8'd236};
            6'd50: rgb = {8'd188, 8'd188, 8'd236};
            6'd51: rgb = {8'd212, 8'd178, 8'd236};
            6'd52: rgb = {8'd236, 8'd174, 8'd236};
            6'd53: rgb = {8'd236, 8'd174, 8'd212};
            6'd54: rgb = {8'd236, 8'd180, 8'd176};
            6'd55: rgb = {8'd228, 8'd196, 8'd144};
            6'd56: rgb = {8'd204, 8'd210, 8'd120};
            6'd57: rgb = {8'd180, 8'd222, 8'd120};
            6'd58: rgb = {8'd168, 8'd226, 8'd144};
            6'd59: rgb = {8'd152, 8'd226, 8'd180};
            6'd60: rgb = {8'd160, 8'd214, 8'd228};
            6'd61: rgb = {8'd160, 8'd162, 8'd160};
            default: rgb = '0;
        endcase
        return rgb;
    endfunction

    // min(255, c * 5 / 4)
    function automatic logic [CHAN_W-1:0] boost(input logic [CHAN_W-1:0] c);
        logic [CHAN_W+2:0] v;
        v = ({3'b0, c} + {1'b0, c, 2'b00}) >> 2;
        return (v > (CHAN_W+3)'(255)) ? 8'd255 : v[CHAN_W-1:0];
    endfunction

    // c * 3 / 4, truncated
    function automatic logic [CHAN_W-1:0] dim(input logic [CHAN_W-1:0] c);
        logic [CHAN_W+1:0] v;
        v = ({2'b0, c} + {1'b0, c, 1'b0}) >> 2;
        return v[CHAN_W-1:0];
    endfunction

endpackage

[hw/rtl/pixel_priority_compositor.sv]
// Top level of the pixel priority compositor: configuration registers and the
// front, queue and back parts. Depends on ppc_pkg, ppc_front, ppc_queue, ppc_back.
`timescale 1ns / 1ps

// A frame store of 2*VIEW_HEIGHT rows by 2*VIEW_WIDTH columns (245760 entries) of
// palette pixels. A write (func 0) composites a sprite or background pixel into one
// entry by priority; a read-out (func 1) returns the entry to background and, inside
// the scroll window, yields window coordinates and RGB after greyscale and emphasis.
// After reset the input stalls while a clearing pass fills the store with opaque
// background colour 0x0F. Items then go through a 4-deep queue into a sequencer
// doing read-modify-write on the store, which has one read and one write port. A
// write or a read-out outside the window does a store read and an update; a visible
// read-out adds palette lookup, greyscale and emphasis. Positions outside the store
// are dropped at the input. Configuration writes take effect at the next clock edge.

module pixel_priority_compositor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ppc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_func,
    input  logic [ppc_pkg::X_W-1:0]           i_x_pos,
    input  logic [ppc_pkg::Y_W-1:0]           i_y_pos,
    input  logic [ppc_pkg::COLOR_W-1:0]       i_color,
    input  logic                              i_is_sprite,
    input  logic [ppc_pkg::PRIO_W-1:0]        i_priority_req,
    input  logic                              i_transparent,
    input  logic                              i_behind_background,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ppc_pkg::CHAN_W-1:0]        o_red,
    output logic [ppc_pkg::CHAN_W-1:0]        o_green,
    output logic [ppc_pkg::CHAN_W-1:0]        o_blue,
    output logic [ppc_pkg::SCR_W-1:0]         o_screen_x,
    output logic [ppc_pkg::SCR_W-1:0]         o_screen_y
);

    logic [ppc_pkg::XSCR_W-1:0]  r_x_scroll;
    logic [ppc_pkg::YSCR_W-1:0]  r_y_scroll;
    logic [ppc_pkg::MASK_W-1:0]  r_display_mask;

    logic                        push;
    logic                        pop;
    logic                        clearing;
    ppc_pkg::t_cmd               cmd;
    ppc_pkg::t_queue_stat        qstat;
    ppc_pkg::t_result            result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_scroll     <= '0;
            r_y_scroll     <= '0;
            r_display_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppc_pkg::CFG_X_SCROLL:     r_x_scroll     <= i_cfg_data[ppc_pkg::XSCR_W-1:0];
                ppc_pkg::CFG_Y_SCROLL:     r_y_scroll     <= i_cfg_data[ppc_pkg::YSCR_W-1:0];
                ppc_pkg::CFG_DISPLAY_MASK: r_display_mask <= i_cfg_data[ppc_pkg::MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ppc_front u_front (
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_func              (i_func),
        .i_x_pos             (i_x_pos),
        .i_y_pos             (i_y_pos),
        .i_color             (i_color),
        .i_is_sprite         (i_is_sprite),
        .i_priority_req      (i_priority_req),
        .i_transparent       (i_transparent),
        .i_behind_background (i_behind_background),
        .i_x_scroll          (r_x_scroll),
        .i_y_scroll          (r_y_scroll),
        .i_q_full            (qstat.full),
        .i_clearing          (clearing),
        .o_push              (push),
        .o_cmd               (cmd)
    );

    ppc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_stat  (qstat)
    );

    ppc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_qstat        (qstat),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .i_display_mask (r_display_mask),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result       (result)
    );

    assign o_red      = result.red;
    assign o_green    = result.green;
    assign o_blue     = result.blue;
    assign o_screen_x = result.scr_x;
    assign o_screen_y = result.scr_y;

endmodule

[hw/rtl/ppc_front.sv]
// Front part: takes input transfers, drops positions outside the store, and
// classifies each item into a queue command. Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_front (
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [ppc_pkg::X_W-1:0]       i_x_pos,
    input  logic [ppc_pkg::Y_W-1:0]       i_y_pos,
    input  logic [ppc_pkg::COLOR_W-1:0]   i_color,
    input  logic                          i_is_sprite,
    input  logic [ppc_pkg::PRIO_W-1:0]    i_priority_req,
    input  logic                          i_transparent,
    input  logic                          i_behind_background,
    input  logic [ppc_pkg::XSCR_W-1:0]    i_x_scroll,
    input  logic [ppc_pkg::YSCR_W-1:0]    i_y_scroll,
    input  logic                          i_q_full,
    input  logic                          i_clearing,
    output logic                          o_push,
    output ppc_pkg::t_cmd                 o_cmd
);

    logic [ppc_pkg::WIN_W-1:0] x_w;
    logic [ppc_pkg::WIN_W-1:0] y_w;
    logic [ppc_pkg::WIN_W-1:0] xs_w;
    logic [ppc_pkg::WIN_W-1:0] ys_w;
    logic                      in_store;
    logic                      in_window;

    assign x_w  = ppc_pkg::WIN_W'(i_x_pos);
    assign y_w  = ppc_pkg::WIN_W'(i_y_pos);
    assign xs_w = ppc_pkg::WIN_W'(i_x_scroll);
    assign ys_w = ppc_pkg::WIN_W'(i_y_scroll);

    assign in_store = (x_w < ppc_pkg::WIN_W'(ppc_pkg::STORE_COLS)) &&
                      (y_w < ppc_pkg::WIN_W'(ppc_pkg::STORE_ROWS));

    assign in_window = (y_w >= ys_w) && (y_w < ys_w + ppc_pkg::WIN_W'(ppc_pkg::VIEW_HEIGHT)) &&
                       (x_w >= xs_w) && (x_w < xs_w + ppc_pkg::WIN_W'(ppc_pkg::VIEW_WIDTH));

    assign o_stall = i_q_full || i_clearing;
    assign o_push  = i_valid && !o_stall && in_store;

    always_comb begin
        o_cmd.func       = i_func;
        o_cmd.in_window  = in_window;
        o_cmd.ent.behind = i_behind_background;
        o_cmd.ent.trans  = i_transparent;
        o_cmd.ent.prio   = i_priority_req;
        o_cmd.ent.sprite = i_is_sprite;
        o_cmd.ent.color  = i_color;
        o_cmd.addr       = ppc_pkg::ADDR_W'(i_y_pos) * ppc_pkg::ADDR_W'(ppc_pkg::STORE_COLS)
                         + ppc_pkg::ADDR_W'(i_x_pos);
        o_cmd.scr_x      = ppc_pkg::SCR_W'(x_w - xs_w);
        o_cmd.scr_y      = ppc_pkg::SCR_W'(y_w - ys_w);
    end

endmodule

[hw/rtl/ppc_queue.sv]
// Short command queue between the front and back parts.
// Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ppc_pkg::t_cmd         i_cmd,
    input  logic                  i_pop,
    output ppc_pkg::t_queue_stat  o_stat
);

    ppc_pkg::t_cmd                r_slot [0:ppc_pkg::QUEUE_DEPTH-1];
    logic [ppc_pkg::QPTR_W-1:0]   r_wptr, n_wptr;
    logic [ppc_pkg::QPTR_W-1:0]   r_rptr, n_rptr;
    logic [ppc_pkg::QCNT_W-1:0]   r_cnt,  n_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == ppc_pkg::QPTR_W'(ppc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == ppc_pkg::QPTR_W'(ppc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == ppc_pkg::QCNT_W'(ppc_pkg::QUEUE_DEPTH));
    assign o_stat.head  = r_slot[r_rptr];

endmodule

[hw/rtl/ppc_back.sv]
// Back part: frame store, clearing pass, read-modify-write sequencer, colour
// path and output register. Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ppc_pkg::t_queue_stat        i_qstat,
    output logic                        o_pop,
    output logic                        o_clearing,
    input  logic [ppc_pkg::MASK_W-1:0]  i_display_mask,
    output logic                        o_valid,
    input  logic                        i_stall,
    output ppc_pkg::t_result            o_result
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_GREY  = 3'd3;
    localparam logic [2:0] S_EMPH  = 3'd4;

    localparam int CW = ppc_pkg::CHAN_W;
    localparam int LW = 2 * ppc_pkg::CHAN_W;

    ppc_pkg::t_entry              r_mem [0:ppc_pkg::STORE_DEPTH-1];
    ppc_pkg::t_entry              r_rdata;
    logic                         mem_we;
    logic [ppc_pkg::ADDR_W-1:0]   mem_waddr;
    ppc_pkg::t_entry              mem_wdata;

    logic [2:0]                   r_state, n_state;
    logic [ppc_pkg::ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic                         r_out_valid, n_out_valid;
    ppc_pkg::t_cmd                r_cmd, n_cmd;
    logic [CW-1:0]                r_red, n_red;
    logic [CW-1:0]                r_green, n_green;
    logic [CW-1:0]                r_blue, n_blue;
    ppc_pkg::t_result             r_out, n_out;

    logic [LW-1:0]                luma;
    logic [3*CW-1:0]              pal_rgb;
    logic [CW-1:0]                e1_r, e1_g, e1_b;
    logic [CW-1:0]                e2_r, e2_g, e2_b;
    logic [CW-1:0]                e3_r, e3_g, e3_b;
    ppc_pkg::t_entry              cleared;

    function automatic logic takes_over(input ppc_pkg::t_entry nw, input ppc_pkg::t_entry old);
        logic res;
        if (!old.sprite) begin
            res = 1'b1;
        end else if (nw.sprite) begin
            res = !nw.trans && (nw.prio < old.prio);
        end else begin
            res = !nw.trans && (old.trans || old.behind);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[i_qstat.head.addr];
    end

    assign pal_rgb = ppc_pkg::palette(r_rdata.color);
    assign luma    = (LW'(r_red) * LW'(77) + LW'(r_green) * LW'(151) + LW'(r_blue) * LW'(28)) >> 8;

    always_comb begin
        cleared        = r_rdata;
        cleared.sprite = 1'b0;
    end

    // emphasis in red, green, blue order
    always_comb begin
        e1_r = r_red;
        e1_g = r_green;
        e1_b = r_blue;
        if (i_display_mask[ppc_pkg::MASK_RED]) begin
            e1_r = ppc_pkg::boost(r_red);
            e1_g = ppc_pkg::dim(r_green);
            e1_b = ppc_pkg::dim(r_blue);
        end
        e2_r = e1_r;
        e2_g = e1_g;
        e2_b = e1_b;
        if (i_display_mask[ppc_pkg::MASK_GREEN]) begin
            e2_r = ppc_pkg::dim(e1_r);
            e2_g = ppc_pkg::boost(e1_g);
            e2_b = ppc_pkg::dim(e1_b);
        end
        e3_r = e2_r;
        e3_g = e2_g;
        e3_b = e2_b;
        if (i_display_mask[ppc_pkg::MASK_BLUE]) begin
            e3_r = ppc_pkg::dim(e2_r);
            e3_g = ppc_pkg::dim(e2_g);
            e3_b = ppc_pkg::boost(e2_b);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && i_stall;
        n_cmd       = r_cmd;
        n_red       = r_red;
        n_green     = r_green;
        n_blue      = r_blue;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_cmd.addr;
        mem_wdata   = r_cmd.ent;
        o_pop       = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = ppc_pkg::RESET_ENTRY;
                if (r_clr_addr == ppc_pkg::ADDR_W'(ppc_pkg::STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_qstat.head;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_IDLE;
                if (r_cmd.func == ppc_pkg::FUNC_WRITE) begin
                    mem_we = takes_over(r_cmd.ent, r_rdata);
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = cleared;
                    if (r_cmd.in_window) begin
                        n_red   = pal_rgb[3*CW-1:2*CW];
                        n_green = pal_rgb[2*CW-1:CW];
                        n_blue  = pal_rgb[CW-1:0];
                        n_state = S_GREY;
                    end
                end
            end
            S_GREY: begin
                if (i_display_mask[ppc_pkg::MASK_GREY]) begin
                    n_red   = luma[CW-1:0];
                    n_green = luma[CW-1:0];
                    n_blue  = luma[CW-1:0];
                end
                n_state = S_EMPH;
            end
            S_EMPH: begin
                if (!r_out_valid || !i_stall) begin
                    n_out.red   = e3_r;
                    n_out.green = e3_g;
                    n_out.blue  = e3_b;
                    n_out.scr_x = r_cmd.scr_x;
                    n_out.scr_y = r_cmd.scr_y;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_out   <= n_out;
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

endmodule

[hw/rtl/ppc_checker.sv]
// Port-level checker for the pixel priority compositor, bound to the top level.
// Depends on ppc_pkg and pixel_priority_compositor.
`timescale 1ns / 1ps

module ppc_assert_chk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_stall,
    input  logic                         o_valid,
    input  logic                         i_stall,
    input  logic [ppc_pkg::CHAN_W-1:0]   o_red,
    input  logic [ppc_pkg::CHAN_W-1:0]   o_green,
    input  logic [ppc_pkg::CHAN_W-1:0]   o_blue,
    input  logic [ppc_pkg::SCR_W-1:0]    o_screen_x,
    input  logic [ppc_pkg::SCR_W-1:0]    o_screen_y
);

    // held result transfer keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid &&
            $stable({o_red, o_green, o_blue, o_screen_x, o_screen_y}))
        else $error("result changed while stalled");

    // the clearing pass blocks input right after reset
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input not stalled during clearing pass");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_row_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_screen_y) < ppc_pkg::VIEW_HEIGHT))
        else $error("window row out of range");

endmodule

bind pixel_priority_compositor ppc_assert_chk u_ppc_assert_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_red      (o_red),
    .o_green    (o_green),
    .o_blue     (o_blue),
    .o_screen_x (o_screen_x),
    .o_screen_y (o_screen_y)
);
